### hdl/hcc_pkg.sv
`timescale 1ns / 1ps

package hcc_pkg;

  localparam int unsigned YearW  = 14;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW   = 5;
  localparam int unsigned HourW  = 5;
  localparam int unsigned WeekW  = 3;

  localparam logic [YearW-1:0]  MaxYear   = 14'd9999;
  localparam logic [MonthW-1:0] LastMonth = 4'd11;
  localparam logic [HourW-1:0]  LastHour  = 5'd23;
  localparam logic [WeekW-1:0]  WeekLen   = 3'd7;
  localparam logic [DayW-1:0]   LeapFeb   = 5'd29;

  // Reciprocal of 100 scaled by 2^19; exact for years below 43699.
  localparam logic [12:0] Recip100 = 13'd5243;

  typedef enum logic [2:0] {
    EV_HOUR   = 3'd0,
    EV_DAY    = 3'd1,
    EV_MONTH  = 3'd2,
    EV_YEAR   = 3'd3,
    EV_LOADED = 3'd4
  } hcc_event_e;

  typedef struct packed {
    logic              cmd;
    logic [YearW-1:0]  load_year;
    logic [MonthW-1:0] load_month;
    logic [DayW-1:0]   load_day;
    logic [HourW-1:0]  load_hour;
  } hcc_in_t;

  typedef struct packed {
    logic [YearW-1:0]  cur_year;
    logic [MonthW-1:0] cur_month;
    logic [DayW-1:0]   cur_day;
    logic [HourW-1:0]  cur_hour;
    hcc_event_e        event_kind;
    logic              week_event;
  } hcc_out_t;

  function automatic logic is_leap(logic [YearW-1:0] y);
    logic [26:0]      prod;
    logic [7:0]       cent_q;
    logic [YearW-1:0] back;
    logic             by_100;
    prod   = 27'(y) * 27'(Recip100);
    cent_q = prod[26:19];
    back   = 14'({cent_q, 6'b0}) + 14'({cent_q, 5'b0}) + 14'({cent_q, 2'b0});
    by_100 = (back == y);
    return ((y[1:0] == 2'b00) && !by_100) || (by_100 && (cent_q[1:0] == 2'b00));
  endfunction

  function automatic logic [DayW-1:0] days_of(logic leap, logic [MonthW-1:0] m);
    logic [DayW-1:0] len;
    case (m)
      4'd0:    len = 5'd31;
      4'd1:    len = leap ? LeapFeb : 5'd28;
      4'd2:    len = 5'd31;
      4'd3:    len = 5'd30;
      4'd4:    len = 5'd31;
      4'd5:    len = 5'd30;
      4'd6:    len = 5'd31;
      4'd7:    len = 5'd31;
      4'd8:    len = 5'd30;
      4'd9:    len = 5'd31;
      4'd10:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

### hdl/hourly_calendar_clock_core.sv
`timescale 1ns / 1ps

// Gregorian calendar clock that advances one hour per tick request.
// Input channel: in_valid_i / in_ready_o carry a request. With cmd = 0 one
// hour passes; with cmd = 1 the date is loaded from the load fields, which
// are saturated to their legal ranges, with the day clamped to the month's
// length, and the week counter cleared.
// Output channel: out_valid_o / out_ready_i carry one result per request:
// the date after the request, the event kind and the week flag.
// The result becomes valid once the request moves from the input register
// into the result register. The block takes one request per cycle while
// the receiver keeps up; each request passes an input register, one step
// of calendar logic and a result register.
// A stalled receiver holds the result register, and the input register
// then fills and deasserts in_ready_o; nothing is dropped or repeated.
// Reset sets the clock to year 0, January 1, hour 0, clears the week
// counter and empties both registers.
module hourly_calendar_clock_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  hcc_pkg::hcc_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output hcc_pkg::hcc_out_t out_data_o
);
  import hcc_pkg::*;

  hcc_in_t           in_q;
  logic              in_valid_q;
  hcc_out_t          out_q, out_d;
  logic              out_valid_q;
  logic              adv;

  logic [YearW-1:0]  year_q, year_d;
  logic [MonthW-1:0] month_q, month_d;
  logic [DayW-1:0]   day_q, day_d;
  logic [HourW-1:0]  hour_q, hour_d;
  logic [WeekW-1:0]  week_q, week_d;

  logic [YearW-1:0]  ld_year, year_sel;
  logic [MonthW-1:0] ld_month, month_sel;
  logic [DayW-1:0]   ld_day, len;
  logic [HourW-1:0]  ld_hour;
  logic [WeekW-1:0]  week_inc;
  logic              leap;
  hcc_event_e        kind;
  logic              week_ev;

  assign adv        = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || adv;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    ld_year  = (in_q.load_year > MaxYear) ? MaxYear : in_q.load_year;
    ld_month = (in_q.load_month > LastMonth) ? LastMonth : in_q.load_month;
    ld_hour  = (in_q.load_hour > LastHour) ? LastHour : in_q.load_hour;
    year_sel  = in_q.cmd ? ld_year : year_q;
    month_sel = in_q.cmd ? ld_month : month_q;
    leap      = is_leap(year_sel);
    len       = days_of(leap, month_sel);
    if (in_q.load_day == '0) begin
      ld_day = 5'd1;
    end else if (in_q.load_day > len) begin
      ld_day = len;
    end else begin
      ld_day = in_q.load_day;
    end
    week_inc = week_q + 3'd1;
  end

  always_comb begin
    year_d  = year_q;
    month_d = month_q;
    day_d   = day_q;
    hour_d  = hour_q;
    week_d  = week_q;
    kind    = EV_HOUR;
    week_ev = 1'b0;
    if (in_q.cmd) begin
      year_d  = ld_year;
      month_d = ld_month;
      day_d   = ld_day;
      hour_d  = ld_hour;
      week_d  = '0;
      kind    = EV_LOADED;
    end else if (hour_q >= LastHour) begin
      hour_d = '0;
      if ((day_q >= len) && (month_q >= LastMonth)) begin
        if (year_q < MaxYear) begin
          year_d = year_q + 14'd1;
        end
        month_d = '0;
        day_d   = 5'd1;
        kind    = EV_YEAR;
      end else if (day_q >= len) begin
        month_d = month_q + 4'd1;
        day_d   = 5'd1;
        kind    = EV_MONTH;
      end else begin
        day_d = day_q + 5'd1;
        kind  = EV_DAY;
        if (week_inc >= WeekLen) begin
          week_ev = 1'b1;
          week_d  = '0;
        end else begin
          week_d = week_inc;
        end
      end
    end else begin
      hour_d = hour_q + 5'd1;
    end
    out_d.cur_year   = year_d;
    out_d.cur_month  = month_d;
    out_d.cur_day    = day_d;
    out_d.cur_hour   = hour_d;
    out_d.event_kind = kind;
    out_d.week_event = week_ev;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      year_q      <= '0;
      month_q     <= '0;
      day_q       <= 5'd1;
      hour_q      <= '0;
      week_q      <= '0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
        year_q      <= year_d;
        month_q     <= month_d;
        day_q       <= day_d;
        hour_q      <= hour_d;
        week_q      <= week_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
    if (adv) begin
      out_q <= out_d;
    end
  end

`ifndef ASSERT_OFF
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.week_event) |-> (out_q.event_kind == EV_DAY))
    else $error("Week event reported without a day advance.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hour_q <= LastHour) && (month_q <= LastMonth) && (day_q >= 5'd1)
    && (day_q <= 5'd31) && (year_q <= MaxYear))
    else $error("Calendar state left its legal range.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    week_q < WeekLen)
    else $error("Week counter reached seven without wrapping.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !adv) |=> (in_valid_q && $stable(in_q)))
    else $error("Held request was lost or changed while the output stalled.");
`endif

endmodule

### sim/hcc_checker.sv
`timescale 1ns / 1ps

module hcc_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  hcc_pkg::hcc_in_t  in_data_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  hcc_pkg::hcc_out_t out_data_i,
  output int                fail_count_o,
  output int                pending_o
);
  import hcc_pkg::*;

  hcc_out_t calendar_q[$];

  int unsigned cal_year;
  int unsigned cal_month;
  int unsigned cal_day;
  int unsigned cal_hour;
  int unsigned cal_week;

  assign pending_o = calendar_q.size();

  function automatic bit leap_year(int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned month_length(int unsigned y, int unsigned m);
    int unsigned lengths [12];
    lengths = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    if (m == 1 && leap_year(y)) begin
      return 29;
    end
    return lengths[m];
  endfunction

  // Applies one request to the calendar copy and returns the result it must produce.
  function automatic hcc_out_t advance_calendar(hcc_in_t req);
    hcc_out_t   res;
    hcc_event_e kind;
    logic       week_hit;
    int unsigned len;
    week_hit = 1'b0;
    if (req.cmd) begin
      cal_year  = (req.load_year > 9999) ? 9999 : req.load_year;
      cal_month = (req.load_month > 11) ? 11 : req.load_month;
      cal_hour  = (req.load_hour > 23) ? 23 : req.load_hour;
      len = month_length(cal_year, cal_month);
      cal_day = (req.load_day == 0) ? 1 : req.load_day;
      if (cal_day > len) begin
        cal_day = len;
      end
      cal_week = 0;
      kind = EV_LOADED;
    end else if (cal_hour >= 23) begin
      len = month_length(cal_year, cal_month);
      cal_hour = 0;
      if (cal_day >= len && cal_month >= 11) begin
        if (cal_year < 9999) begin
          cal_year++;
        end
        cal_month = 0;
        cal_day = 1;
        kind = EV_YEAR;
      end else if (cal_day >= len) begin
        cal_month++;
        cal_day = 1;
        kind = EV_MONTH;
      end else begin
        cal_day++;
        cal_week++;
        kind = EV_DAY;
        if (cal_week >= 7) begin
          week_hit = 1'b1;
          cal_week = 0;
        end
      end
    end else begin
      cal_hour++;
      kind = EV_HOUR;
    end
    res.cur_year   = cal_year[YearW-1:0];
    res.cur_month  = cal_month[MonthW-1:0];
    res.cur_day    = cal_day[DayW-1:0];
    res.cur_hour   = cal_hour[HourW-1:0];
    res.event_kind = kind;
    res.week_event = week_hit;
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    $display("checker: %s", msg);
    fail_count_o++;
  endtask

  task automatic compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      report_mismatch($sformatf("%s expected %0d, got %0d", name, want, got));
    end
  endtask

  initial begin
    fail_count_o = 0;
  end

  // Results are taken before requests, since a result never belongs to a
  // request accepted at the same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    hcc_out_t want;
    if (!rst_ni) begin
      cal_year  = 0;
      cal_month = 0;
      cal_day   = 1;
      cal_hour  = 0;
      cal_week  = 0;
      calendar_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (calendar_q.size() == 0) begin
          report_mismatch("result arrived with no request outstanding");
        end else begin
          want = calendar_q.pop_front();
          compare_field("cur_year", want.cur_year, out_data_i.cur_year);
          compare_field("cur_month", want.cur_month, out_data_i.cur_month);
          compare_field("cur_day", want.cur_day, out_data_i.cur_day);
          compare_field("cur_hour", want.cur_hour, out_data_i.cur_hour);
          compare_field("event_kind", want.event_kind, out_data_i.event_kind);
          compare_field("week_event", want.week_event, out_data_i.week_event);
        end
      end
      if (in_valid_i && in_ready_i) begin
        calendar_q.push_back(advance_calendar(in_data_i));
      end
    end
  end

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import hcc_pkg::*;

  localparam int unsigned ItemTarget = 950;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldCycles = 300;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid;
  logic     in_ready;
  hcc_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  hcc_out_t out_data;

  int fail_count;
  int pending;

  int unsigned cycles;
  int unsigned sent;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          start_hold;
  bit          hold_done;

  int unsigned notable_years [12];

  hourly_calendar_clock_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  hcc_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
  end

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic hcc_in_t tick_request();
    hcc_in_t req;
    req.cmd        = 1'b0;
    req.load_year  = YearW'($urandom);
    req.load_month = MonthW'($urandom);
    req.load_day   = DayW'($urandom);
    req.load_hour  = HourW'($urandom);
    return req;
  endfunction

  function automatic hcc_in_t load_request(int unsigned y, int unsigned m,
                                           int unsigned d, int unsigned h);
    hcc_in_t req;
    req.cmd        = 1'b1;
    req.load_year  = YearW'(y);
    req.load_month = MonthW'(m);
    req.load_day   = DayW'(d);
    req.load_hour  = HourW'(h);
    return req;
  endfunction

  task automatic push_request(hcc_in_t req);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk_i); while (!in_ready);
    sent++;
    if (sent == ItemTarget / 3) begin
      send_idle_pct = 60;
      recv_idle_pct = 23;
    end else if (sent == 2 * ItemTarget / 3) begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  endtask

  task automatic push_ticks(int unsigned count);
    repeat (count) begin
      if (sent < ItemTarget) begin
        push_request(tick_request());
      end
    end
  endtask

  initial begin
    out_ready = 1'b0;
    hold_done = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (start_hold && !hold_done) begin
        hold_done = 1'b1;
        repeat (HoldCycles) begin
          out_ready <= 1'b0;
          @(negedge clk_i);
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    int unsigned pick;
    hcc_in_t     tick_ones;
    rst_ni        = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    cycles        = 0;
    sent          = 0;
    start_hold    = 1'b0;
    send_idle_pct = 23;
    recv_idle_pct = 60;
    notable_years = '{0, 4, 100, 400, 1900, 2000, 2023, 2024, 2100, 9998, 9999, 1};
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    push_request(tick_request());
    push_request(load_request(16383, 15, 31, 31));
    push_request(tick_request());
    push_request(load_request(0, 1, 31, 0));
    push_request(load_request(1900, 1, 29, 23));
    push_request(tick_request());
    push_request(load_request(2000, 1, 29, 23));
    push_request(tick_request());
    push_request(load_request(2024, 1, 28, 23));
    push_request(tick_request());
    push_request(load_request(2023, 3, 31, 5));
    push_request(load_request(100, 0, 0, 0));
    push_request(load_request(400, 1, 30, 23));
    push_request(tick_request());
    push_request(load_request(9998, 11, 31, 23));
    push_request(tick_request());
    push_request(load_request(1234, 10, 30, 22));
    push_request(tick_request());
    push_request(tick_request());
    push_request(load_request(5, 12, 15, 24));
    tick_ones = '1;
    tick_ones.cmd = 1'b0;
    push_request(tick_ones);
    push_request(load_request(0, 0, 1, 0));

    start_hold = 1'b1;
    while (sent < ItemTarget) begin
      pick = $urandom_range(9);
      if (pick < 7) begin
        push_request(load_request(notable_years[$urandom_range(11)], $urandom_range(11),
                                  $urandom_range(26, 31), $urandom_range(18, 23)));
        push_ticks($urandom_range(1, 80));
      end else if (pick == 7) begin
        push_request(load_request($urandom_range(9999), $urandom_range(11),
                                  $urandom_range(1, 20), $urandom_range(23)));
        push_ticks($urandom_range(170, 260));
      end else begin
        push_request(load_request($urandom, $urandom, $urandom, $urandom));
        push_ticks($urandom_range(0, 5));
      end
    end
    @(negedge clk_i);
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
